// ===== rtl/kti_pkg.sv =====
// shared types and constants for the keyframe track interpolator
`default_nettype none
package kti_pkg;
   localparam int MAX_KEYS = 64;
   localparam int IDX_W = $clog2(MAX_KEYS);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [1:0] CMD_SET = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_MOVE = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic [31:0] key_time;
      logic signed [31:0] key_value;
      logic [31:0] new_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0] status;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/keyframe_track_interpolator.sv =====
// keyframe track interpolator top level: sorted key table, sequencer and restoring divider
`default_nettype none
// One animation track of up to 64 keys (time, value) held in two memories, each with
// one registered read port and one write port, kept sorted by time. One word is taken
// at a time; req_stall stays high until the result word has been taken. A command
// scans the table one entry at a time, a read state then a compare state, through the
// memory read port, inserts or deletes by moving one entry at a time (read, then write),
// and a query that interpolates runs a 16-step restoring divider (one quotient bit per
// cycle) and one 33x17 multiply. A move costs a delete plus a set. No clearing pass is
// needed.
module keyframe_track_interpolator (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire kti_pkg::req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output kti_pkg::rsp_type rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN, S_SHUP_RD, S_SHUP_WR, S_SHDN_RD, S_SHDN_WR,
      S_QRD, S_QWAIT, S_DIV, S_MUL, S_ADD, S_RESP
   } state_type;

   localparam int IW = kti_pkg::IDX_W;
   localparam int CW = kti_pkg::CNT_W;

   logic [31:0] tmem [kti_pkg::MAX_KEYS];
   logic [31:0] vmem [kti_pkg::MAX_KEYS];

   state_type state_ff, state_in;
   kti_pkg::req_type req_ff, req_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic [31:0] tl_ff, tl_in, vl_ff, vl_in, val_ff, val_in;
   logic        moving_ff, moving_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [31:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [4:0]  step_ff, step_in;
   logic signed [49:0] prod_ff, prod_in;
   kti_pkg::rsp_type rsp_ff, rsp_in;

   logic [IW-1:0] raddr, waddr;
   logic          we;
   logic [31:0]   wt, wv, rt, rv;

   always_ff @(posedge clock) begin
      if (we) begin
         tmem[waddr] <= wt;
         vmem[waddr] <= wv;
      end
      rt <= tmem[raddr];
      rv <= vmem[raddr];
   end

   logic [31:0] t_cmd;
   logic [32:0] rem_sh;
   logic signed [32:0] dv;
   logic signed [49:0] pv;
   logic [CW-1:0] last;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      tl_in = tl_ff;
      vl_in = vl_ff;
      val_in = val_ff;
      moving_in = moving_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      prod_in = prod_ff;
      rsp_in = rsp_ff;
      t_cmd = moving_ff ? req_ff.new_time : req_ff.key_time;
      raddr = idx_ff[IW-1:0];
      waddr = idx_ff[IW-1:0];
      we = 1'b0;
      wt = t_cmd;
      wv = val_ff;
      rem_sh = {rem_ff, 1'b0};
      dv = $signed({rv[31], rv}) - $signed({vl_ff[31], vl_ff});
      pv = dv * $signed({1'b0, quo_ff});
      last = cnt_ff - CW'(1);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               val_in = req_data.key_value;
               moving_in = 1'b0;
               idx_in = '0;
               rsp_in = '{value: '0, status: kti_pkg::ST_OK};
               if (req_data.command == kti_pkg::CMD_QUERY) begin
                  if (cnt_ff == '0) begin
                     rsp_in.status = kti_pkg::ST_EMPTY;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_QRD;
                  end
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               if (req_ff.command == kti_pkg::CMD_SET || moving_ff) begin
                  if (cnt_ff == CW'(kti_pkg::MAX_KEYS)) begin
                     rsp_in.status = kti_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     tl_in = {{(32-CW){1'b0}}, cnt_ff};
                     state_in = S_SHUP_RD;
                  end
               end else begin
                  rsp_in.status = kti_pkg::ST_NOT_FOUND;
                  state_in = S_RESP;
               end
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rt < t_cmd) begin
               idx_in = idx_ff + CW'(1);
               state_in = S_SCAN_RD;
            end else if (rt == t_cmd) begin
               if (req_ff.command == kti_pkg::CMD_SET || moving_ff) begin
                  we = 1'b1;
                  wt = rt;
                  state_in = S_RESP;
               end else begin
                  if (req_ff.command == kti_pkg::CMD_MOVE) val_in = rv;
                  if (req_ff.command == kti_pkg::CMD_MOVE
                      && req_ff.new_time == req_ff.key_time) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_SHDN_RD;
                  end
               end
            end else if (req_ff.command == kti_pkg::CMD_SET || moving_ff) begin
               if (cnt_ff == CW'(kti_pkg::MAX_KEYS)) begin
                  rsp_in.status = kti_pkg::ST_FULL;
                  state_in = S_RESP;
               end else begin
                  tl_in = {{(32-CW){1'b0}}, cnt_ff};
                  state_in = S_SHUP_RD;
               end
            end else begin
               rsp_in.status = kti_pkg::ST_NOT_FOUND;
               state_in = S_RESP;
            end
         end
         // tl holds the write pointer while shifting up
         S_SHUP_RD: begin
            if (tl_ff[CW-1:0] == idx_ff) begin
               we = 1'b1;
               waddr = idx_ff[IW-1:0];
               cnt_in = cnt_ff + CW'(1);
               state_in = S_RESP;
            end else begin
               raddr = IW'(tl_ff[CW-1:0] - CW'(1));
               state_in = S_SHUP_WR;
            end
         end
         S_SHUP_WR: begin
            we = 1'b1;
            waddr = tl_ff[IW-1:0];
            wt = rt;
            wv = rv;
            tl_in = tl_ff - 32'd1;
            state_in = S_SHUP_RD;
         end
         S_SHDN_RD: begin
            if (idx_ff + CW'(1) >= cnt_ff) begin
               cnt_in = last;
               if (req_ff.command == kti_pkg::CMD_MOVE) begin
                  moving_in = 1'b1;
                  idx_in = '0;
                  state_in = S_SCAN_RD;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               raddr = IW'(idx_ff + CW'(1));
               state_in = S_SHDN_WR;
            end
         end
         S_SHDN_WR: begin
            we = 1'b1;
            wt = rt;
            wv = rv;
            idx_in = idx_ff + CW'(1);
            state_in = S_SHDN_RD;
         end
         S_QRD: begin
            state_in = S_QWAIT;
         end
         S_QWAIT: begin
            if (rt > req_ff.key_time && idx_ff != '0) begin
               tl_in = req_ff.key_time - tl_ff;
               dvs_in = rt - tl_ff;
               rem_in = req_ff.key_time - tl_ff;
               quo_in = '0;
               step_in = '0;
               state_in = S_DIV;
            end else if (rt > req_ff.key_time || idx_ff == last) begin
               rsp_in.value = rv;
               state_in = S_RESP;
            end else begin
               tl_in = rt;
               vl_in = rv;
               idx_in = idx_ff + CW'(1);
               state_in = S_QRD;
            end
         end
         // restoring divide of (t-tl)<<16 by (tr-tl), one quotient bit per cycle
         S_DIV: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = 32'(rem_sh - {1'b0, dvs_ff});
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               quo_in = {quo_ff[14:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd15) state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = pv;
            state_in = S_ADD;
         end
         S_ADD: begin
            rsp_in.value = vl_ff + 32'(prod_ff >>> 16);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      tl_ff <= tl_in;
      vl_ff <= vl_in;
      val_ff <= val_in;
      moving_ff <= moving_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data = rsp_ff;

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(kti_pkg::MAX_KEYS)) else $error("key count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE || state_ff == S_QRD || state_ff == S_DIV |=> $stable(cnt_ff)
      || $past(state_ff) == S_IDLE) else $error("count changed outside edit");
endmodule
`default_nettype wire
